[sv/hpsm_pkg.sv]
// hpsm_pkg: shared widths, reset values, register indexes and the
// command/status structs for the Hall period speed meter.
// No dependencies; every other file refers to it by scoped names.
package hpsm_pkg;

    localparam int TIME_W   = 32;
    localparam int CIRC_W   = 24;
    localparam int PPR_W    = 8;
    localparam int SPEED_W  = 16;
    localparam int COUNT_W  = 16;
    localparam int DIVD_W   = CIRC_W + 8;          // circumference scaled by 256
    localparam int DIVS_W   = PPR_W + TIME_W;      // pulses_per_rev * interval
    localparam int STEP_W   = $clog2(DIVD_W);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = CIRC_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CIRC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PPR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

    localparam logic [CIRC_W-1:0]  CIRC_RESET  = 24'd1244600;
    localparam logic [PPR_W-1:0]   PPR_RESET   = 8'd28;
    localparam logic [SPEED_W-1:0] LIMIT_RESET = 16'd25600;

    typedef struct packed {
        logic load_in;    // latch a new edge, update interval and counters
        logic load_div;   // form the divisor and seed the divider
        logic step_div;   // one restoring-division step
        logic load_out;   // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic div_last;   // the current step is the final quotient bit
    } status_t;

endpackage

[sv/hpsm_ctrl.sv]
// hpsm_ctrl: sequencing state machine of the Hall period speed meter.
// Depends on hpsm_pkg for cmd_t and status_t; drives hpsm_dp by commands.
module hpsm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  hpsm_pkg::status_t status,
    output hpsm_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.load_in  = in_valid && in_ready;
        cmd.load_div = (state_reg == ST_MUL);
        cmd.step_div = (state_reg == ST_DIV);
        cmd.load_out = (state_reg == ST_FIN) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_last)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    // the divider keeps running until its last step
    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && !status.div_last |=> (state_reg == ST_DIV))
        else $error("divider left early");

    // an accepted edge always starts the multiply step
    a_accept_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> (state_reg == ST_MUL))
        else $error("accepted edge not processed");

endmodule

[sv/hpsm_dp.sv]
// hpsm_dp: datapath of the Hall period speed meter: configuration registers,
// edge state, divisor multiply, bit-serial restoring divider, output register.
// Depends on hpsm_pkg; sequenced by hpsm_ctrl through cmd_t / status_t.
module hpsm_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hpsm_pkg::cmd_t                    cmd,
    output hpsm_pkg::status_t                 status,
    input  logic                              cfg_we,
    input  logic [hpsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hpsm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [hpsm_pkg::TIME_W-1:0]       edge_time_us,
    output logic [hpsm_pkg::SPEED_W-1:0]      speed_q8,
    output logic [hpsm_pkg::COUNT_W-1:0]      edge_count,
    output logic                              accepted,
    output logic [hpsm_pkg::TIME_W-1:0]       interval_us
);

    localparam int DIVD_W = hpsm_pkg::DIVD_W;
    localparam int DIVS_W = hpsm_pkg::DIVS_W;
    localparam int STEP_W = hpsm_pkg::STEP_W;

    logic [hpsm_pkg::CIRC_W-1:0]  circ_reg;
    logic [hpsm_pkg::PPR_W-1:0]   ppr_reg;
    logic [hpsm_pkg::SPEED_W-1:0] limit_reg;

    logic [hpsm_pkg::TIME_W-1:0]  last_time_reg;
    logic [hpsm_pkg::COUNT_W-1:0] tick_reg;
    logic [hpsm_pkg::SPEED_W-1:0] held_reg;
    logic [hpsm_pkg::TIME_W-1:0]  interval_reg;
    logic [hpsm_pkg::TIME_W-1:0]  interval_next;

    logic [DIVS_W-1:0] div_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [STEP_W-1:0] step_reg;

    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              fits;
    logic              acc_w;

    logic [hpsm_pkg::SPEED_W-1:0] speed_out_reg;
    logic [hpsm_pkg::COUNT_W-1:0] count_out_reg;
    logic                         acc_out_reg;
    logic [hpsm_pkg::TIME_W-1:0]  interval_out_reg;

    assign interval_next = edge_time_us - last_time_reg;

    // restoring division: shift in one dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = (trial >= {1'b0, div_reg});

    assign status.div_last = (step_reg == STEP_W'(DIVD_W - 1));

    // zero divisor means infinite speed: reject
    assign acc_w = (div_reg != '0)
                && (quo_reg[DIVD_W-1:hpsm_pkg::SPEED_W] == '0)
                && (quo_reg[hpsm_pkg::SPEED_W-1:0] < limit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circ_reg      <= hpsm_pkg::CIRC_RESET;
            ppr_reg       <= hpsm_pkg::PPR_RESET;
            limit_reg     <= hpsm_pkg::LIMIT_RESET;
            last_time_reg <= '0;
            tick_reg      <= '0;
            held_reg      <= '0;
            step_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    hpsm_pkg::CFG_CIRC:  circ_reg  <= cfg_data;
                    hpsm_pkg::CFG_PPR:   ppr_reg   <= cfg_data[hpsm_pkg::PPR_W-1:0];
                    hpsm_pkg::CFG_LIMIT: limit_reg <= cfg_data[hpsm_pkg::SPEED_W-1:0];
                    default:             ;
                endcase
            end
            if (cmd.load_in)
            begin
                last_time_reg <= edge_time_us;
                tick_reg      <= tick_reg + 1'b1;
            end
            if (cmd.load_div)
                step_reg <= '0;
            else if (cmd.step_div)
                step_reg <= step_reg + 1'b1;
            if (cmd.load_out && acc_w)
                held_reg <= quo_reg[hpsm_pkg::SPEED_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            interval_reg <= interval_next;
        if (cmd.load_div)
        begin
            div_reg <= DIVS_W'(ppr_reg) * DIVS_W'(interval_reg);
            rem_reg <= '0;
            quo_reg <= {circ_reg, 8'd0};
        end
        else if (cmd.step_div)
        begin
            rem_reg <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
        end
        if (cmd.load_out)
        begin
            speed_out_reg    <= acc_w ? quo_reg[hpsm_pkg::SPEED_W-1:0] : held_reg;
            count_out_reg    <= tick_reg;
            acc_out_reg      <= acc_w;
            interval_out_reg <= interval_reg;
        end
    end

    assign speed_q8    = speed_out_reg;
    assign edge_count  = count_out_reg;
    assign accepted    = acc_out_reg;
    assign interval_us = interval_out_reg;

    // an accepted speed lies below the limit
    a_acc_below: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out && acc_w |-> (quo_reg[hpsm_pkg::SPEED_W-1:0] < limit_reg))
        else $error("accepted speed not below limit");

    // the interval is the wrapped difference to the previous edge
    a_interval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> (interval_reg == $past(edge_time_us - last_time_reg)))
        else $error("interval mismatch");

    // the edge counter advances by one per accepted edge
    a_tick: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> (tick_reg == $past(tick_reg) + 1'b1))
        else $error("edge counter did not advance");

endmodule

[sv/hall_period_speed_meter.sv]
// hall_period_speed_meter: top level of the period-measuring wheel tachometer.
// Depends on hpsm_pkg, hpsm_ctrl and hpsm_dp.
//
// Usage:
//   Input channel (in_valid/in_ready, edge_time_us): one transaction per Hall
//   rising edge, carrying its free-running microsecond timestamp.
//   Output channel (out_valid/out_ready): one transaction per edge with the
//   held speed (Q8 m/s), the wrapped edge count, the accepted flag and the
//   interval since the previous edge.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): write
//   circumference (0), pulses per revolution (1) or speed limit (2) while the
//   block is idle; cfg_ready is always high, other indexes are dropped.
// Sequencing: the clock edge that accepts an edge transaction also latches the
//   stamp and interval; then follow the pulses*interval multiply, the restoring
//   divider at one bit per cycle, and the load of the output register, after
//   which out_valid rises. in_ready rises in the same cycle as out_valid, and
//   no new edge is taken until the previous result has been loaded.
// Reset: rst_n (asynchronous, active low) restores the default registers and
//   clears the last timestamp, edge count and held speed to zero.
// Stall: a result waits in the output register while the next edge is
//   measured; if the receiver still stalls, the block holds at the final step.
module hall_period_speed_meter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [hpsm_pkg::TIME_W-1:0]       edge_time_us,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hpsm_pkg::SPEED_W-1:0]      speed_q8,
    output logic [hpsm_pkg::COUNT_W-1:0]      edge_count,
    output logic                              accepted,
    output logic [hpsm_pkg::TIME_W-1:0]       interval_us,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hpsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hpsm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    hpsm_pkg::cmd_t    cmd;
    hpsm_pkg::status_t status;

    // configuration writes are always accepted
    assign cfg_ready = 1'b1;

    hpsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    hpsm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .edge_time_us (edge_time_us),
        .speed_q8     (speed_q8),
        .edge_count   (edge_count),
        .accepted     (accepted),
        .interval_us  (interval_us)
    );

endmodule

[bench/tb_hall_period_speed_meter.sv]
// tb_hall_period_speed_meter: self-checking bench for the Hall period speed meter.
// Depends on hpsm_pkg and hall_period_speed_meter. It predicts every result from a
// shadow of the wheel registers and the edge state, and checks each result on arrival.
module tb_hall_period_speed_meter;

    // Index 3 is outside the register list; the block must drop the write.
    localparam logic [hpsm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 40;          // wait after the final drain for any stray result
    localparam int MAX_SHOWN     = 10;

    typedef struct packed {
        logic [hpsm_pkg::SPEED_W-1:0] speed_q8;
        logic [hpsm_pkg::COUNT_W-1:0] edge_count;
        logic                         accepted;
        logic [hpsm_pkg::TIME_W-1:0]  interval_us;
    } speed_reading_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [hpsm_pkg::TIME_W-1:0]     edge_time_us = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [hpsm_pkg::SPEED_W-1:0]    speed_q8;
    logic [hpsm_pkg::COUNT_W-1:0]    edge_count;
    logic                            accepted;
    logic [hpsm_pkg::TIME_W-1:0]     interval_us;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [hpsm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [hpsm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the wheel registers, tracked on every accepted write.
    logic [hpsm_pkg::CIRC_W-1:0]     wheel_circ  = hpsm_pkg::CIRC_RESET;
    logic [hpsm_pkg::PPR_W-1:0]      wheel_ppr   = hpsm_pkg::PPR_RESET;
    logic [hpsm_pkg::SPEED_W-1:0]    plaus_limit = hpsm_pkg::LIMIT_RESET;

    // Shadow of the measurement state: last stamp, edge tally, held speed.
    logic [hpsm_pkg::TIME_W-1:0]     prev_stamp = '0;
    logic [hpsm_pkg::COUNT_W-1:0]    edge_tally = '0;
    logic [hpsm_pkg::SPEED_W-1:0]    held_q8    = '0;

    speed_reading_t        pending_readings[$];
    int unsigned           mismatch_count = 0;
    int unsigned           send_idle_pct  = 0;
    int unsigned           recv_idle_pct  = 0;

    hall_period_speed_meter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .edge_time_us (edge_time_us),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .speed_q8     (speed_q8),
        .edge_count   (edge_count),
        .accepted     (accepted),
        .interval_us  (interval_us),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop: far beyond the slowest legal run of the whole edge sequence.
    initial
    begin
        #12_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Advance the shadow state by one Hall edge and return the result it must produce.
    // The interval wraps modulo 2^32; a zero interval or zero pulse count is treated as
    // infinite speed and never replaces the held value.
    function automatic speed_reading_t advance_tachometer(
        input logic [hpsm_pkg::TIME_W-1:0] stamp);
        speed_reading_t              r;
        logic [hpsm_pkg::DIVD_W-1:0] per_pulse;
        logic [hpsm_pkg::TIME_W-1:0] cand;
        r.interval_us = stamp - prev_stamp;
        r.accepted    = 1'b0;
        prev_stamp    = stamp;
        edge_tally    = edge_tally + 1'b1;
        if (r.interval_us != '0 && wheel_ppr != '0)
        begin
            // Divide by the pulse count first; the floor is the same and nothing overflows.
            per_pulse = {wheel_circ, 8'h00} / wheel_ppr;
            cand      = per_pulse / r.interval_us;
            if (cand < {16'h0000, plaus_limit})
            begin
                held_q8    = cand[hpsm_pkg::SPEED_W-1:0];
                r.accepted = 1'b1;
            end
        end
        r.speed_q8   = held_q8;
        r.edge_count = edge_tally;
        return r;
    endfunction

    // Drive out_ready; recv_idle_pct sets how often the receiver stalls.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check every output transaction against the oldest pending reading.
    always @(posedge clk)
    begin
        speed_reading_t got;
        speed_reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {speed_q8, edge_count, accepted, interval_us};
            if (pending_readings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("unexpected result: speed %0d count %0d acc %0d interval %0d",
                             got.speed_q8, got.edge_count, got.accepted, got.interval_us);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display({"mismatch: expected speed %0d count %0d acc %0d ",
                                  "interval %0d, got speed %0d count %0d acc %0d interval %0d"},
                                 want.speed_q8, want.edge_count, want.accepted,
                                 want.interval_us, got.speed_q8, got.edge_count,
                                 got.accepted, got.interval_us);
                end
            end
        end
    end

    // Send one edge transaction. Keep in_valid high straight into the next edge when
    // the sender does not idle, so it is never lowered and raised in the same step.
    task automatic send_edge(input logic [hpsm_pkg::TIME_W-1:0] stamp);
        int unsigned gap;
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        edge_time_us <= stamp;
        do @(posedge clk); while (!in_ready);
        pending_readings.push_back(advance_tachometer(stamp));
    endtask

    // Drop in_valid and hold until every pending reading has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register; call only while the block is idle.
    task automatic write_register(input logic [hpsm_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [hpsm_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            hpsm_pkg::CFG_CIRC:  wheel_circ  = data[hpsm_pkg::CIRC_W-1:0];
            hpsm_pkg::CFG_PPR:   wheel_ppr   = data[hpsm_pkg::PPR_W-1:0];
            hpsm_pkg::CFG_LIMIT: plaus_limit = data[hpsm_pkg::SPEED_W-1:0];
            default:             ;
        endcase
        @(posedge clk);
    endtask

    // Pick a fresh wheel setup, extremes included; junk in the unused data bits
    // must be ignored.
    task automatic pick_wheel_setup();
        int unsigned                  roll;
        logic [hpsm_pkg::CIRC_W-1:0]  circ;
        logic [hpsm_pkg::PPR_W-1:0]   ppr;
        logic [hpsm_pkg::SPEED_W-1:0] lim;
        wait_idle();
        roll = $urandom_range(0, 99);
        if (roll < 10)      circ = '1;
        else if (roll < 20) circ = 24'd1;
        else if (roll < 25) circ = '0;
        else                circ = hpsm_pkg::CIRC_W'($urandom_range(200_000, 3_000_000));
        roll = $urandom_range(0, 99);
        if (roll < 10)      ppr = '1;
        else if (roll < 20) ppr = 8'd1;
        else if (roll < 24) ppr = '0;
        else                ppr = hpsm_pkg::PPR_W'($urandom_range(1, 64));
        roll = $urandom_range(0, 99);
        if (roll < 10)      lim = '1;
        else if (roll < 18) lim = 16'd1;
        else if (roll < 21) lim = '0;
        else                lim = hpsm_pkg::SPEED_W'($urandom_range(500, 65535));
        write_register(hpsm_pkg::CFG_CIRC, circ);
        write_register(hpsm_pkg::CFG_PPR, {16'($urandom()), ppr});
        write_register(hpsm_pkg::CFG_LIMIT, {8'($urandom()), lim});
        if ($urandom_range(0, 3) == 0)
            write_register(CFG_SPARE, hpsm_pkg::CFG_DATA_W'($urandom()));
    endtask

    // Reset wheel: first edge measures from time zero, limit boundary, repeated stamp,
    // timestamp wrap.
    task automatic test_reset_wheel();
        send_edge(32'd0);               // zero interval from the reset stamp
        send_edge(32'd445);             // just under the limit
        send_edge(32'd889);             // just over the limit
        send_edge(32'd889);             // same stamp again
        send_edge(32'd100_889);         // slow wheel
        send_edge(32'hFFFF_FFFF);       // top of the stamp range
        send_edge(32'h0000_0005);       // stamp wraps, short interval
        send_edge(32'h0000_1005);
        wait_idle();
    endtask

    // Register corners: exact limit, zero limit, zero pulses, zero circumference,
    // dropped index, widest circumference.
    task automatic test_register_corners();
        write_register(hpsm_pkg::CFG_CIRC, 24'd100);
        write_register(hpsm_pkg::CFG_PPR, 24'd1);
        write_register(hpsm_pkg::CFG_LIMIT, 24'd25600);
        send_edge(prev_stamp + 32'd1);  // candidate equals the limit: reject
        send_edge(prev_stamp + 32'd2);  // half of it: accept
        wait_idle();
        write_register(hpsm_pkg::CFG_LIMIT, 24'hFF0000);
        send_edge(prev_stamp + 32'd1);  // zero limit rejects everything
        wait_idle();
        write_register(hpsm_pkg::CFG_LIMIT, 24'h00FFFF);
        write_register(hpsm_pkg::CFG_PPR, 24'hFFFF00);
        send_edge(prev_stamp + 32'd3);  // zero pulse count: infinite speed
        wait_idle();
        write_register(hpsm_pkg::CFG_PPR, 24'd1);
        write_register(hpsm_pkg::CFG_CIRC, 24'd0);
        send_edge(prev_stamp + 32'd7);  // zero circumference gives speed zero
        wait_idle();
        write_register(CFG_SPARE, 24'hFFFFFF);
        send_edge(prev_stamp + 32'd1);  // the spare write must change nothing
        wait_idle();
        write_register(hpsm_pkg::CFG_CIRC, 24'hFFFFFF);
        send_edge(prev_stamp + 32'd1);
        send_edge(prev_stamp + 32'd65537);  // largest speed the limit lets through
        wait_idle();
        write_register(hpsm_pkg::CFG_PPR, 24'd255);
        write_register(hpsm_pkg::CFG_LIMIT, 24'd1);
        send_edge(prev_stamp + 32'hFFFF_FFFF);
        wait_idle();
    endtask

    // Random traffic in chunks, a new wheel setup before each chunk. Most intervals
    // aim at a speed below the limit so the held value keeps moving.
    task automatic test_random_traffic(input int unsigned n_edges,
                                       input int unsigned snd_pct,
                                       input int unsigned rcv_pct);
        int unsigned                 roll;
        logic [hpsm_pkg::DIVD_W-1:0] per_pulse;
        logic [hpsm_pkg::TIME_W-1:0] gap_us;
        logic [hpsm_pkg::TIME_W-1:0] stamp;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int unsigned i = 0; i < n_edges; i++)
        begin
            if (i % 75 == 0)
                pick_wheel_setup();
            per_pulse = (wheel_ppr != '0) ? {wheel_circ, 8'h00} / wheel_ppr
                                          : {wheel_circ, 8'h00};
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                gap_us = per_pulse / $urandom_range(1, (plaus_limit != '0) ? plaus_limit : 1);
                gap_us = gap_us + $urandom_range(0, 2);
                if (gap_us == '0)
                    gap_us = 32'd1;
            end
            else if (roll < 70) gap_us = $urandom_range(1, 1000);
            else if (roll < 78) gap_us = '0;
            else if (roll < 88) gap_us = $urandom() - prev_stamp;
            else                gap_us = $urandom_range(1, 32'h00FF_FFFF);
            stamp = prev_stamp + gap_us;
            send_edge(stamp);
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_wheel();
        test_register_corners();
        test_random_traffic(300, 23, 67);
        test_random_traffic(300, 67, 23);
        test_random_traffic(300, 0, 0);

        // Drain, then give any stray result time to show up.
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
